/* hw/rtl/tbq_pkg.sv */
package tbq_pkg;

    // Command codes carried in the kind field.
    localparam logic [3:0] KIND_TICK       = 4'd0;
    localparam logic [3:0] KIND_START      = 4'd1;
    localparam logic [3:0] KIND_RESTART    = 4'd2;
    localparam logic [3:0] KIND_PAUSE      = 4'd3;
    localparam logic [3:0] KIND_STOP       = 4'd4;
    localparam logic [3:0] KIND_SET_PERIOD = 4'd5;
    localparam logic [3:0] KIND_SET_VALUE  = 4'd6;
    localparam logic [3:0] KIND_FETCH      = 4'd7;
    localparam logic [3:0] KIND_NEXT       = 4'd8;

    // Response status codes.
    localparam logic [1:0] STAT_OK          = 2'd0;
    localparam logic [1:0] STAT_INVALID     = 2'd1;
    localparam logic [1:0] STAT_NOT_RUNNING = 2'd2;
    localparam logic [1:0] STAT_EMPTY       = 2'd3;

    localparam logic [31:0] TICKS_MAX = 32'hFFFF_FFFF;

    // Number of timers that the periodic mask can mark.
    localparam int MASK_BITS = 16;

    typedef struct packed {
        logic [3:0]  kind;
        logic [3:0]  timer_index;
        logic [31:0] tick_delta;
        logic [31:0] period_ticks_in;
        logic [31:0] payload_value;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  fetched_timer;
        logic [31:0] fetched_value;
        logic [31:0] next_expiry;
        logic        wake;
    } rsp_t;

    // Result of the shared compare and subtract unit.
    typedef struct packed {
        logic        a_lt_b;
        logic [31:0] b_minus_a;
    } cmp_res_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_DECODE,
        FSM_TICK,
        FSM_MIN,
        FSM_FETCH,
        FSM_SCHED,
        FSM_REMOVE,
        FSM_RESP
    } fsm_t;

endpackage

/* hw/rtl/tbq_cmp_unit.sv */
module tbq_cmp_unit (
    input  logic [31:0]       op_a,
    input  logic [31:0]       op_b,
    output tbq_pkg::cmp_res_t res
);

    logic [32:0] diff;

    // One subtractor gives both the difference and the ordering.
    assign diff          = {1'b0, op_b} - {1'b0, op_a};
    assign res.b_minus_a = diff[31:0];
    assign res.a_lt_b    = !diff[32] && (diff[31:0] != 32'd0);

endmodule

/* hw/rtl/timer_bank_with_expiry_queue.sv */
// Bank of NUM_TIMERS countdown timers with a FIFO of expiries, driven by one
// command beat at a time through a small sequencer around a single shared
// compare and subtract unit. The block takes one command and returns exactly
// one response beat for it; cmd_stall stays high until that command's work is
// done. A tick with a non-zero count walks the linked timers one per cycle,
// and a next-expiry query with an empty queue walks them likewise. Other
// commands go through decode, schedule and response states, a successful fetch
// also through a fetch state, and each list that must be compacted (stop, start
// or restart of a queued timer, fetch) is walked entry by entry in one pass, at
// most two passes. The response sits in an output register, so a new
// command can be accepted while the previous response still waits.
module timer_bank_with_expiry_queue #(
    parameter int NUM_TIMERS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [15:0]     cfg_wdata,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  tbq_pkg::cmd_t   cmd,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output tbq_pkg::rsp_t   rsp
);

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW = $clog2(NUM_TIMERS + 1);

    tbq_pkg::fsm_t state_reg, state_next;
    tbq_pkg::cmd_t cmd_reg, cmd_next;
    tbq_pkg::rsp_t rsp_reg;
    logic          rsp_valid_reg;

    logic [15:0]   mask_reg;

    logic [31:0]   period_reg    [NUM_TIMERS];
    logic [31:0]   period_next   [NUM_TIMERS];
    logic [31:0]   remain_reg    [NUM_TIMERS];
    logic [31:0]   remain_next   [NUM_TIMERS];
    logic [31:0]   value_reg     [NUM_TIMERS];
    logic [31:0]   value_next    [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] active_reg, active_next;
    logic [NUM_TIMERS-1:0] paused_reg, paused_next;
    logic [NUM_TIMERS-1:0] queued_reg, queued_next;
    logic [NUM_TIMERS-1:0] linked_reg, linked_next;

    logic [IW-1:0] link_mem  [NUM_TIMERS];
    logic [IW-1:0] fifo_mem  [NUM_TIMERS];
    logic          link_we, fifo_we;
    logic [IW-1:0] link_waddr, link_wdata, fifo_waddr, fifo_wdata;
    logic [CW-1:0] link_count_reg, link_count_next;
    logic [CW-1:0] exp_count_reg, exp_count_next;

    logic [CW-1:0] i_reg, i_next, j_reg, j_next;
    logic [IW-1:0] k_reg, k_next, rm_val_reg, rm_val_next;
    logic          rm_sel_reg, rm_sel_next;
    logic          rm_link_reg, rm_link_next, rm_fifo_reg, rm_fifo_next;
    logic [1:0]    status_reg, status_next;
    logic [3:0]    ftimer_reg, ftimer_next;
    logic [31:0]   fvalue_reg, fvalue_next;
    logic [31:0]   nexp_reg, nexp_next;
    logic          wake_reg, wake_next;

    logic          cmd_take, rsp_take, rsp_free;
    logic [IW-1:0] t_idx, lk, fk, addr, rm_entry;
    logic          idx_ok, bad_idx, walk_last, rm_last, rm_keep, k_periodic;
    logic [CW-1:0] rm_count;
    logic [31:0]   rd_period, rd_remain, rd_value;
    logic [31:0]   cmp_a, cmp_b;
    tbq_pkg::cmp_res_t cmp_res;

    // Handshakes.
    assign cmd_take  = cmd_valid && !cmd_stall;
    assign cmd_stall = (state_reg != tbq_pkg::FSM_IDLE);
    assign rsp_take  = rsp_valid_reg && !rsp_stall;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Decoded command and list read ports.
    assign t_idx   = IW'(cmd_reg.timer_index);
    assign idx_ok  = (9'(cmd_reg.timer_index) < 9'(NUM_TIMERS));
    assign bad_idx = (cmd_reg.kind >= tbq_pkg::KIND_START)
                  && (cmd_reg.kind <= tbq_pkg::KIND_SET_VALUE) && !idx_ok;
    assign lk      = link_mem[i_reg[IW-1:0]];
    assign fk      = fifo_mem[i_reg[IW-1:0]];
    assign walk_last = ((i_reg + CW'(1)) >= link_count_reg);

    // Single timer read address: the command's timer, the fetched one, or
    // the timer under the walk pointer.
    always_comb
    begin
        case (state_reg)
            tbq_pkg::FSM_DECODE: addr = t_idx;
            tbq_pkg::FSM_FETCH:  addr = k_reg;
            default:             addr = lk;
        endcase
    end

    assign rd_period  = period_reg[addr];
    assign rd_remain  = remain_reg[addr];
    assign rd_value   = value_reg[addr];
    assign k_periodic = (9'(addr) < 9'(tbq_pkg::MASK_BITS)) && mask_reg[4'(addr)];

    // List compaction pass.
    assign rm_entry = rm_sel_reg ? fk : lk;
    assign rm_count = rm_sel_reg ? exp_count_reg : link_count_reg;
    assign rm_keep  = (rm_entry != rm_val_reg);
    assign rm_last  = ((i_reg + CW'(1)) >= rm_count);

    // Shared compare unit operands: tick compares elapsed with remaining,
    // the query compares remaining with the running minimum.
    assign cmp_a = (state_reg == tbq_pkg::FSM_TICK) ? cmd_reg.tick_delta : rd_remain;
    assign cmp_b = (state_reg == tbq_pkg::FSM_TICK) ? rd_remain : nexp_reg;

    tbq_cmp_unit u_cmp (
        .op_a (cmp_a),
        .op_b (cmp_b),
        .res  (cmp_res)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tbq_pkg::FSM_IDLE:
            begin
                if (cmd_take)
                    state_next = tbq_pkg::FSM_DECODE;
            end
            tbq_pkg::FSM_DECODE:
            begin
                if (cmd_reg.kind == tbq_pkg::KIND_TICK && cmd_reg.tick_delta != 32'd0
                    && link_count_reg != '0)
                    state_next = tbq_pkg::FSM_TICK;
                else if (cmd_reg.kind == tbq_pkg::KIND_FETCH && exp_count_reg != '0)
                    state_next = tbq_pkg::FSM_FETCH;
                else if (cmd_reg.kind == tbq_pkg::KIND_NEXT && exp_count_reg == '0
                         && link_count_reg != '0)
                    state_next = tbq_pkg::FSM_MIN;
                else
                    state_next = tbq_pkg::FSM_SCHED;
            end
            tbq_pkg::FSM_TICK, tbq_pkg::FSM_MIN:
            begin
                if (walk_last)
                    state_next = tbq_pkg::FSM_RESP;
            end
            tbq_pkg::FSM_FETCH:
                state_next = tbq_pkg::FSM_SCHED;
            tbq_pkg::FSM_SCHED:
            begin
                if (rm_link_reg && link_count_reg != '0)
                    state_next = tbq_pkg::FSM_REMOVE;
                else if (!rm_link_reg && rm_fifo_reg && exp_count_reg != '0)
                    state_next = tbq_pkg::FSM_REMOVE;
                else if (!rm_link_reg && !rm_fifo_reg)
                    state_next = tbq_pkg::FSM_RESP;
            end
            tbq_pkg::FSM_REMOVE:
            begin
                if (rm_last)
                    state_next = tbq_pkg::FSM_SCHED;
            end
            tbq_pkg::FSM_RESP:
            begin
                if (rsp_free)
                    state_next = tbq_pkg::FSM_IDLE;
            end
            default:
                state_next = tbq_pkg::FSM_IDLE;
        endcase
    end

    // Datapath updates for each step of the sequencer.
    always_comb
    begin
        cmd_next        = cmd_reg;
        period_next     = period_reg;
        remain_next     = remain_reg;
        value_next      = value_reg;
        active_next     = active_reg;
        paused_next     = paused_reg;
        queued_next     = queued_reg;
        linked_next     = linked_reg;
        link_count_next = link_count_reg;
        exp_count_next  = exp_count_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        rm_val_next     = rm_val_reg;
        rm_sel_next     = rm_sel_reg;
        rm_link_next    = rm_link_reg;
        rm_fifo_next    = rm_fifo_reg;
        status_next     = status_reg;
        ftimer_next     = ftimer_reg;
        fvalue_next     = fvalue_reg;
        nexp_next       = nexp_reg;
        wake_next       = wake_reg;
        link_we         = 1'b0;
        link_waddr      = link_count_reg[IW-1:0];
        link_wdata      = t_idx;
        fifo_we         = 1'b0;
        fifo_waddr      = exp_count_reg[IW-1:0];
        fifo_wdata      = lk;

        case (state_reg)
            tbq_pkg::FSM_IDLE:
            begin
                if (cmd_take)
                begin
                    cmd_next     = cmd;
                    status_next  = tbq_pkg::STAT_OK;
                    ftimer_next  = 4'd0;
                    fvalue_next  = 32'd0;
                    nexp_next    = 32'd0;
                    wake_next    = 1'b0;
                    i_next       = '0;
                    j_next       = '0;
                    rm_link_next = 1'b0;
                    rm_fifo_next = 1'b0;
                end
            end

            tbq_pkg::FSM_DECODE:
            begin
                if (bad_idx)
                    status_next = tbq_pkg::STAT_INVALID;
                else
                begin
                    case (cmd_reg.kind)
                        tbq_pkg::KIND_TICK:
                            nexp_next = 32'd0;
                        tbq_pkg::KIND_START, tbq_pkg::KIND_RESTART:
                        begin
                            if (rd_period == 32'd0)
                                status_next = tbq_pkg::STAT_INVALID;
                            else
                            begin
                                if (!linked_reg[t_idx] && link_count_reg < CW'(NUM_TIMERS))
                                begin
                                    linked_next[t_idx] = 1'b1;
                                    link_we            = 1'b1;
                                    link_count_next    = link_count_reg + CW'(1);
                                end
                                value_next[t_idx] = cmd_reg.payload_value;
                                if (cmd_reg.kind == tbq_pkg::KIND_RESTART || !paused_reg[t_idx])
                                begin
                                    remain_next[t_idx] = rd_period;
                                    if (queued_reg[t_idx])
                                    begin
                                        queued_next[t_idx] = 1'b0;
                                        rm_fifo_next       = 1'b1;
                                        rm_val_next        = t_idx;
                                    end
                                end
                                paused_next[t_idx] = 1'b0;
                                active_next[t_idx] = 1'b1;
                            end
                        end
                        tbq_pkg::KIND_PAUSE:
                        begin
                            if (active_reg[t_idx])
                            begin
                                active_next[t_idx] = 1'b0;
                                paused_next[t_idx] = 1'b1;
                            end
                            else if (!paused_reg[t_idx])
                                status_next = tbq_pkg::STAT_NOT_RUNNING;
                        end
                        tbq_pkg::KIND_STOP:
                        begin
                            active_next[t_idx] = 1'b0;
                            paused_next[t_idx] = 1'b0;
                            rm_val_next        = t_idx;
                            if (linked_reg[t_idx])
                            begin
                                linked_next[t_idx] = 1'b0;
                                rm_link_next       = 1'b1;
                            end
                            if (queued_reg[t_idx])
                            begin
                                queued_next[t_idx] = 1'b0;
                                rm_fifo_next       = 1'b1;
                            end
                        end
                        tbq_pkg::KIND_SET_PERIOD:
                        begin
                            if (cmd_reg.period_ticks_in == 32'd0
                                || cmd_reg.period_ticks_in == tbq_pkg::TICKS_MAX)
                                status_next = tbq_pkg::STAT_INVALID;
                            else
                                period_next[t_idx] = cmd_reg.period_ticks_in;
                        end
                        tbq_pkg::KIND_SET_VALUE:
                            value_next[t_idx] = cmd_reg.payload_value;
                        tbq_pkg::KIND_FETCH:
                        begin
                            if (exp_count_reg == '0)
                                status_next = tbq_pkg::STAT_EMPTY;
                            else
                            begin
                                // The head of the queue appears only once, so
                                // removing it by value pops the head.
                                k_next          = fk;
                                queued_next[fk] = 1'b0;
                                rm_val_next     = fk;
                                rm_fifo_next    = 1'b1;
                            end
                        end
                        tbq_pkg::KIND_NEXT:
                            nexp_next = (exp_count_reg != '0) ? 32'd0 : tbq_pkg::TICKS_MAX;
                        default:
                            status_next = tbq_pkg::STAT_INVALID;
                    endcase
                end
            end

            tbq_pkg::FSM_TICK:
            begin
                // One linked timer per cycle: count down or expire.
                if (active_reg[lk])
                begin
                    if (cmp_res.a_lt_b)
                        remain_next[lk] = cmp_res.b_minus_a;
                    else
                    begin
                        if (k_periodic)
                            remain_next[lk] = rd_period;
                        else
                            active_next[lk] = 1'b0;
                        if (!queued_reg[lk] && exp_count_reg < CW'(NUM_TIMERS))
                        begin
                            queued_next[lk] = 1'b1;
                            fifo_we         = 1'b1;
                            exp_count_next  = exp_count_reg + CW'(1);
                            wake_next       = 1'b1;
                        end
                    end
                end
                i_next = i_reg + CW'(1);
            end

            tbq_pkg::FSM_MIN:
            begin
                if (active_reg[lk] && cmp_res.a_lt_b)
                    nexp_next = rd_remain;
                i_next = i_reg + CW'(1);
            end

            tbq_pkg::FSM_FETCH:
            begin
                ftimer_next = 4'(k_reg);
                fvalue_next = rd_value;
                if (!active_reg[k_reg] && !paused_reg[k_reg] && linked_reg[k_reg])
                begin
                    linked_next[k_reg] = 1'b0;
                    rm_link_next       = 1'b1;
                end
            end

            tbq_pkg::FSM_SCHED:
            begin
                // Start the next pending compaction, link order first.
                i_next = '0;
                j_next = '0;
                if (rm_link_reg)
                begin
                    rm_sel_next  = 1'b0;
                    rm_link_next = 1'b0;
                end
                else if (rm_fifo_reg)
                begin
                    rm_sel_next  = 1'b1;
                    rm_fifo_next = 1'b0;
                end
            end

            tbq_pkg::FSM_REMOVE:
            begin
                if (rm_keep)
                begin
                    j_next = j_reg + CW'(1);
                    if (rm_sel_reg)
                    begin
                        fifo_we    = 1'b1;
                        fifo_waddr = j_reg[IW-1:0];
                        fifo_wdata = rm_entry;
                    end
                    else
                    begin
                        link_we    = 1'b1;
                        link_waddr = j_reg[IW-1:0];
                        link_wdata = rm_entry;
                    end
                end
                i_next = i_reg + CW'(1);
                if (rm_last)
                begin
                    if (rm_sel_reg)
                        exp_count_next = j_next;
                    else
                        link_count_next = j_next;
                end
            end

            default:
            begin
            end
        endcase
    end

    // Control and timer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tbq_pkg::FSM_IDLE;
            mask_reg       <= '0;
            period_reg     <= '{default: '0};
            remain_reg     <= '{default: '0};
            value_reg      <= '{default: '0};
            active_reg     <= '0;
            paused_reg     <= '0;
            queued_reg     <= '0;
            linked_reg     <= '0;
            link_count_reg <= '0;
            exp_count_reg  <= '0;
            rm_link_reg    <= 1'b0;
            rm_fifo_reg    <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_we)
                mask_reg <= cfg_wdata;
            period_reg     <= period_next;
            remain_reg     <= remain_next;
            value_reg      <= value_next;
            active_reg     <= active_next;
            paused_reg     <= paused_next;
            queued_reg     <= queued_next;
            linked_reg     <= linked_next;
            link_count_reg <= link_count_next;
            exp_count_reg  <= exp_count_next;
            rm_link_reg    <= rm_link_next;
            rm_fifo_reg    <= rm_fifo_next;
            if (state_reg == tbq_pkg::FSM_RESP && rsp_free)
                rsp_valid_reg <= 1'b1;
            else if (rsp_take)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Working registers of the sequencer and the response beat.
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
        rm_val_reg <= rm_val_next;
        rm_sel_reg <= rm_sel_next;
        status_reg <= status_next;
        ftimer_reg <= ftimer_next;
        fvalue_reg <= fvalue_next;
        nexp_reg   <= nexp_next;
        wake_reg   <= wake_next;
        if (state_reg == tbq_pkg::FSM_RESP && rsp_free)
        begin
            rsp_reg.status        <= status_reg;
            rsp_reg.fetched_timer <= ftimer_reg;
            rsp_reg.fetched_value <= fvalue_reg;
            rsp_reg.next_expiry   <= nexp_reg;
            rsp_reg.wake          <= wake_reg;
        end
    end

    // Link order and expiry queue storage.
    always_ff @(posedge clk)
    begin
        if (link_we)
            link_mem[link_waddr] <= link_wdata;
        if (fifo_we)
            fifo_mem[fifo_waddr] <= fifo_wdata;
    end

`ifndef ASSERT_OFF
    // The lists never hold more entries than there are timers.
    a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (link_count_reg <= CW'(NUM_TIMERS)) && (exp_count_reg <= CW'(NUM_TIMERS)))
        else $error("list count beyond timer count");

    // Between commands the queued flags match the queue length.
    a_queue_matches_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tbq_pkg::FSM_IDLE) |-> ($countones(queued_reg) == exp_count_reg))
        else $error("queued flags disagree with expiry queue length");

    // Between commands the linked flags match the link order length.
    a_links_match_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tbq_pkg::FSM_IDLE) |-> ($countones(linked_reg) == link_count_reg))
        else $error("linked flags disagree with link order length");

    // A timer is never running and paused at once.
    a_active_not_paused: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg & paused_reg) == '0)
        else $error("timer both active and paused");
`endif

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam int NT = 16;
    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_CYCLES = 300;

    logic            clk;
    logic            rst_n;
    logic            cfg_we;
    logic [15:0]     cfg_wdata;
    logic            cmd_valid = 1'b0;
    logic            cmd_stall;
    tbq_pkg::cmd_t   cmd = '0;
    logic            rsp_valid;
    logic            rsp_stall = 1'b0;
    tbq_pkg::rsp_t   rsp;

    timer_bank_with_expiry_queue #(.NUM_TIMERS(NT)) dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
    );

    // Shadow copy of the timer bank.
    logic [15:0]   sh_mask;
    logic [31:0]   sh_period [NT] = '{default: '0};
    logic [31:0]   sh_remain [NT] = '{default: '0};
    logic [31:0]   sh_value [NT] = '{default: '0};
    logic [NT-1:0] sh_active = '0;
    logic [NT-1:0] sh_paused = '0;
    logic [NT-1:0] sh_queued = '0;
    logic [NT-1:0] sh_linked = '0;
    logic [3:0]    sh_order [NT] = '{default: '0};
    int            sh_order_n = 0;
    logic [3:0]    sh_fifo [NT] = '{default: '0};
    int            sh_fifo_n = 0;

    tbq_pkg::cmd_t pending_cmds [$];
    tbq_pkg::rsp_t expected_rsps [$];
    int   errors = 0;
    int   rsp_seen = 0;
    int   idle_cycles = 0;
    bit   hold_off = 0;
    bit   took_cmd = 0;

    function automatic void drop_order(input logic [3:0] t);
        int j;
        j = 0;
        for (int i = 0; i < sh_order_n; i++)
            if (sh_order[i] != t)
            begin
                sh_order[j] = sh_order[i];
                j++;
            end
        sh_order_n = j;
    endfunction

    function automatic void drop_fifo(input logic [3:0] t);
        int j;
        j = 0;
        for (int i = 0; i < sh_fifo_n; i++)
            if (sh_fifo[i] != t)
            begin
                sh_fifo[j] = sh_fifo[i];
                j++;
            end
        sh_fifo_n = j;
    endfunction

    // Work out the response to one command and update the shadow state.
    function automatic tbq_pkg::rsp_t bank_response(input tbq_pkg::cmd_t c);
        tbq_pkg::rsp_t r;
        logic [3:0] t, k;
        r = '0;
        t = c.timer_index;
        case (c.kind)
            tbq_pkg::KIND_TICK:
                if (c.tick_delta != 0)
                    for (int i = 0; i < sh_order_n; i++)
                    begin
                        k = sh_order[i];
                        if (!sh_active[k])
                            continue;
                        if (sh_remain[k] > c.tick_delta)
                        begin
                            sh_remain[k] -= c.tick_delta;
                            continue;
                        end
                        if (sh_mask[k])
                            sh_remain[k] = sh_period[k];
                        else
                            sh_active[k] = 1'b0;
                        if (!sh_queued[k] && sh_fifo_n < NT)
                        begin
                            sh_queued[k] = 1'b1;
                            sh_fifo[sh_fifo_n] = k;
                            sh_fifo_n++;
                            r.wake = 1'b1;
                        end
                    end
            tbq_pkg::KIND_START, tbq_pkg::KIND_RESTART:
                if (sh_period[t] == 0)
                    r.status = tbq_pkg::STAT_INVALID;
                else
                begin
                    if (!sh_linked[t] && sh_order_n < NT)
                    begin
                        sh_linked[t] = 1'b1;
                        sh_order[sh_order_n] = t;
                        sh_order_n++;
                    end
                    sh_value[t] = c.payload_value;
                    if (c.kind == tbq_pkg::KIND_RESTART || !sh_paused[t])
                    begin
                        sh_remain[t] = sh_period[t];
                        if (sh_queued[t])
                        begin
                            drop_fifo(t);
                            sh_queued[t] = 1'b0;
                        end
                    end
                    sh_paused[t] = 1'b0;
                    sh_active[t] = 1'b1;
                end
            tbq_pkg::KIND_PAUSE:
                if (sh_active[t])
                begin
                    sh_active[t] = 1'b0;
                    sh_paused[t] = 1'b1;
                end
                else if (!sh_paused[t])
                    r.status = tbq_pkg::STAT_NOT_RUNNING;
            tbq_pkg::KIND_STOP:
            begin
                sh_active[t] = 1'b0;
                sh_paused[t] = 1'b0;
                if (sh_linked[t])
                begin
                    drop_order(t);
                    sh_linked[t] = 1'b0;
                end
                if (sh_queued[t])
                begin
                    drop_fifo(t);
                    sh_queued[t] = 1'b0;
                end
            end
            tbq_pkg::KIND_SET_PERIOD:
                if (c.period_ticks_in == 0 || c.period_ticks_in == tbq_pkg::TICKS_MAX)
                    r.status = tbq_pkg::STAT_INVALID;
                else
                    sh_period[t] = c.period_ticks_in;
            tbq_pkg::KIND_SET_VALUE:
                sh_value[t] = c.payload_value;
            tbq_pkg::KIND_FETCH:
                if (sh_fifo_n == 0)
                    r.status = tbq_pkg::STAT_EMPTY;
                else
                begin
                    k = sh_fifo[0];
                    for (int i = 1; i < sh_fifo_n; i++)
                        sh_fifo[i-1] = sh_fifo[i];
                    sh_fifo_n--;
                    sh_queued[k] = 1'b0;
                    r.fetched_timer = k;
                    r.fetched_value = sh_value[k];
                    if (!sh_active[k] && !sh_paused[k] && sh_linked[k])
                    begin
                        drop_order(k);
                        sh_linked[k] = 1'b0;
                    end
                end
            tbq_pkg::KIND_NEXT:
                if (sh_fifo_n == 0)
                begin
                    r.next_expiry = tbq_pkg::TICKS_MAX;
                    for (int i = 0; i < sh_order_n; i++)
                    begin
                        k = sh_order[i];
                        if (sh_active[k] && sh_remain[k] < r.next_expiry)
                            r.next_expiry = sh_remain[k];
                    end
                end
            default:
                r.status = tbq_pkg::STAT_INVALID;
        endcase
        return r;
    endfunction

    // Clock.
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Driver: offers queued commands with random gaps, changes at the falling edge.
    int gap_left = 0;
    always @(negedge clk)
    begin
        if (!cmd_valid || took_cmd)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                cmd_valid <= 1'b0;
            end
            else if (pending_cmds.size() > 0 && rst_n)
            begin
                cmd <= pending_cmds.pop_front();
                cmd_valid <= 1'b1;
                gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                          : (($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : 0);
            end
            else
                cmd_valid <= 1'b0;
        end
    end

    // Command acceptance, latched at the rising edge.
    always @(posedge clk)
    begin
        took_cmd <= rst_n && cmd_valid && !cmd_stall;
        if (rst_n && cmd_valid && !cmd_stall)
            expected_rsps.push_back(bank_response(cmd));
    end

    // Receiver stall, including one long hold-off counted here.
    int  stall_left = 0;
    int  hold_left = 0;
    bit  hold_started = 0;
    always @(negedge clk)
    begin
        if (hold_off && !hold_started)
        begin
            hold_started <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                        : $urandom_range(0, 3);
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= 1'b0;
    end

    // Monitor: compares each response beat with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            rsp_seen++;
            if (expected_rsps.size() == 0)
            begin
                $error("response beat with nothing expected");
                errors++;
            end
            else
            begin
                tbq_pkg::rsp_t e;
                e = expected_rsps.pop_front();
                if (rsp.status !== e.status)
                begin
                    $error("status: expected %0d, got %0d", e.status, rsp.status);
                    errors++;
                end
                if (rsp.fetched_timer !== e.fetched_timer)
                begin
                    $error("fetched_timer: expected %0d, got %0d",
                           e.fetched_timer, rsp.fetched_timer);
                    errors++;
                end
                if (rsp.fetched_value !== e.fetched_value)
                begin
                    $error("fetched_value: expected %h, got %h",
                           e.fetched_value, rsp.fetched_value);
                    errors++;
                end
                if (rsp.next_expiry !== e.next_expiry)
                begin
                    $error("next_expiry: expected %h, got %h",
                           e.next_expiry, rsp.next_expiry);
                    errors++;
                end
                if (rsp.wake !== e.wake)
                begin
                    $error("wake: expected %0d, got %0d", e.wake, rsp.wake);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no beat on either channel.
    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL timer_bank_with_expiry_queue");
            $finish;
        end
    end

    function automatic tbq_pkg::cmd_t rand_cmd();
        tbq_pkg::cmd_t c;
        int sel;
        c.kind = 4'($urandom_range(0, 8));
        if ($urandom_range(0, 30) == 0)
            c.kind = 4'($urandom_range(9, 15));
        c.timer_index = 4'($urandom_range(0, 15));
        sel = $urandom_range(0, 9);
        c.tick_delta = (sel < 6) ? $urandom_range(1, 60)
                     : (sel < 8) ? $urandom()
                     : ((sel == 8) ? 32'd0 : tbq_pkg::TICKS_MAX);
        sel = $urandom_range(0, 9);
        c.period_ticks_in = (sel < 7) ? $urandom_range(1, 100)
                          : (sel == 7) ? $urandom()
                          : ((sel == 8) ? 32'd0 : tbq_pkg::TICKS_MAX);
        c.payload_value = $urandom();
        return c;
    endfunction

    function automatic tbq_pkg::cmd_t mk(input logic [3:0] k, input logic [3:0] t,
                                         input logic [31:0] el, input logic [31:0] p,
                                         input logic [31:0] v);
        tbq_pkg::cmd_t c;
        c.kind = k;
        c.timer_index = t;
        c.tick_delta = el;
        c.period_ticks_in = p;
        c.payload_value = v;
        return c;
    endfunction

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || cmd_valid || expected_rsps.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_mask(input logic [15:0] m);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        sh_mask = m;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Stimulus and end of run.
    initial
    begin
        logic [15:0] masks [4];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        sh_mask = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed beats covering special cases and field extremes.
        write_mask(16'hFFFF);
        pending_cmds.push_back(mk(tbq_pkg::KIND_START, 4'd0, 0, 0, 32'h1));
        pending_cmds.push_back(mk(tbq_pkg::KIND_SET_PERIOD, 4'd0, 0, 32'd0, 0));
        pending_cmds.push_back(mk(tbq_pkg::KIND_SET_PERIOD, 4'd0, 0, tbq_pkg::TICKS_MAX, 0));
        pending_cmds.push_back(mk(tbq_pkg::KIND_SET_PERIOD, 4'd0, 0, 32'hFFFF_FFFE, 0));
        pending_cmds.push_back(mk(tbq_pkg::KIND_SET_PERIOD, 4'd15, 0, 32'd3, 0));
        pending_cmds.push_back(mk(tbq_pkg::KIND_PAUSE, 4'd15, 0, 0, 0));
        pending_cmds.push_back(mk(tbq_pkg::KIND_START, 4'd15, 0, 0, tbq_pkg::TICKS_MAX));
        pending_cmds.push_back(mk(tbq_pkg::KIND_START, 4'd0, 0, 0, 32'h0));
        pending_cmds.push_back(mk(tbq_pkg::KIND_NEXT, 4'd0, 0, 0, 0));
        pending_cmds.push_back(mk(tbq_pkg::KIND_FETCH, 4'd0, 0, 0, 0));
        pending_cmds.push_back(mk(tbq_pkg::KIND_TICK, 4'd0, 32'd0, 0, 0));
        pending_cmds.push_back(mk(tbq_pkg::KIND_TICK, 4'd0, 32'd3, 0, 0));
        pending_cmds.push_back(mk(tbq_pkg::KIND_TICK, 4'd0, tbq_pkg::TICKS_MAX, 0, 0));
        pending_cmds.push_back(mk(tbq_pkg::KIND_NEXT, 4'd0, 0, 0, 0));
        pending_cmds.push_back(mk(tbq_pkg::KIND_PAUSE, 4'd0, 0, 0, 0));
        pending_cmds.push_back(mk(tbq_pkg::KIND_PAUSE, 4'd0, 0, 0, 0));
        pending_cmds.push_back(mk(tbq_pkg::KIND_START, 4'd0, 0, 0, 32'h55));
        pending_cmds.push_back(mk(tbq_pkg::KIND_RESTART, 4'd15, 0, 0, 32'hAA));
        pending_cmds.push_back(mk(tbq_pkg::KIND_SET_VALUE, 4'd0, 0, 0, 32'hDEAD_BEEF));
        pending_cmds.push_back(mk(tbq_pkg::KIND_FETCH, 4'd0, 0, 0, 0));
        pending_cmds.push_back(mk(tbq_pkg::KIND_FETCH, 4'd0, 0, 0, 0));
        pending_cmds.push_back(mk(tbq_pkg::KIND_STOP, 4'd0, 0, 0, 0));
        pending_cmds.push_back(mk(4'd15, 4'd0, 0, 0, 0));
        pending_cmds.push_back(mk(4'd9, 4'd3, 0, 0, 0));
        wait_drained();

        // Random phases under several mask settings, extremes included.
        masks[0] = 16'h0000;
        masks[1] = 16'hA5A5;
        masks[2] = 16'($urandom());
        masks[3] = 16'hFFFF;
        for (int ph = 0; ph < 4; ph++)
        begin
            write_mask(masks[ph]);
            for (int n = 0; n < 150; n++)
            begin
                tbq_pkg::cmd_t c;
                // Well-formed arming sequences make up much of the stream.
                if ($urandom_range(0, 3) == 0)
                begin
                    c = mk(tbq_pkg::KIND_SET_PERIOD, 4'($urandom_range(0, 15)), 0,
                           $urandom_range(1, 80), 0);
                    pending_cmds.push_back(c);
                    c.kind = tbq_pkg::KIND_START;
                    c.payload_value = $urandom();
                    pending_cmds.push_back(c);
                    n++;
                end
                else
                    pending_cmds.push_back(rand_cmd());
            end
            // Long receiver hold-off while the sender keeps offering beats.
            if (ph == 1)
                hold_off = 1'b1;
            // Sender pauses until every expected response has come.
            wait_drained();
        end

        $display("Covered %0d response beats over four mask settings,", rsp_seen);
        $display("with a long receiver hold-off and a full drain between phases.");
        if (errors == 0)
            $display("PASS timer_bank_with_expiry_queue");
        else
            $display("FAIL timer_bank_with_expiry_queue");
        $finish;
    end

endmodule
